// File: rtl/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared types, constants and helpers for the multi-pattern byte matcher.
// ----------------------------------------------------------------------------
package mpbm_pkg;

  localparam int NODES_DEF        = 256;
  localparam int PATTERNS_DEF     = 32;
  localparam int PACKET_BYTES_DEF = 65536;

  typedef enum logic [1:0] {
    FN_CLEAR   = 2'd0,
    FN_PATTERN = 2'd1,
    FN_BUILD   = 2'd2,
    FN_SCAN    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NODE_FULL = 2'd1,
    ST_PAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_LD, S_LD_W, S_LD_END, S_LD_MASK,
    S_BD_INIT, S_BR_RD, S_BR_CHK, S_BQ, S_BQ_W, S_BN_F,
    S_BC_RD, S_BC_CHK, S_BF_RD, S_BF_CHK, S_BM1, S_BM2, S_BD_DONE,
    S_SC, S_SC_CHK, S_SC_M, S_SC_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] packet_id;
  } cmd_t;

  typedef struct packed {
    logic [31:0] packet_id_out;
    logic [15:0] position;
    logic [7:0]  node_id;
    logic        match_valid;
    logic [4:0]  pattern_number;
    logic        result_last;
    logic        build_report;
    logic [1:0]  status;
    logic [8:0]  node_count;
  } res_t;

  // fold upper-case ascii letters onto lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// File: rtl/mpbm_if.sv
// ----------------------------------------------------------------------------
// mpbm_cmd_if / mpbm_rsp_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mpbm_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic        last;
  logic [31:0] packet_id;

  modport source (output valid, func, data_byte, last, packet_id, input ready);
  modport sink   (input valid, func, data_byte, last, packet_id, output ready);
endinterface

interface mpbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_id_out;
  logic [15:0] position;
  logic [7:0]  node_id;
  logic        match_valid;
  logic [4:0]  pattern_number;
  logic        result_last;
  logic        build_report;
  logic [1:0]  status;
  logic [8:0]  node_count;

  modport source (output valid, packet_id_out, position, node_id, match_valid,
                  pattern_number, result_last, build_report, status, node_count,
                  input ready);
  modport sink   (input valid, packet_id_out, position, node_id, match_valid,
                  pattern_number, result_last, build_report, status, node_count,
                  output ready);
endinterface

// File: rtl/multi_pattern_byte_matcher_top.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_top
// Case-insensitive multi-pattern matcher with a registered result stage.
// ----------------------------------------------------------------------------
// pattern byte: S_LD, S_LD_W unless dropped, S_LD_END, S_LD_MASK on its last byte;
//   scan byte: S_SC/S_SC_CHK per fail link, S_SC_M, S_SC_EMIT per pattern reported
// build: S_BR_RD/S_BR_CHK per root goto entry, S_BQ/S_BQ_W/S_BN_F per queued node,
//   S_BC_RD/S_BC_CHK per goto entry, S_BF_RD/S_BF_CHK per child and fail link,
//   S_BM1/S_BM2 per child; one transaction at a time; reset and clear sweep the
//   goto, fail and mask memories, no input transaction is taken during it
module multi_pattern_byte_matcher_top #(
  parameter int NODES        = mpbm_pkg::NODES_DEF,
  parameter int PATTERNS     = mpbm_pkg::PATTERNS_DEF,
  parameter int PACKET_BYTES = mpbm_pkg::PACKET_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  mpbm_cmd_if.sink   cmd,
  mpbm_rsp_if.source rsp
);

  mpbm_pkg::cmd_t core_cmd;
  mpbm_pkg::res_t core_res;
  mpbm_pkg::res_t ob;
  logic           core_valid;
  logic           core_ready;
  logic           ov;

  assign core_cmd.func      = cmd.func;
  assign core_cmd.data_byte = cmd.data_byte;
  assign core_cmd.last      = cmd.last;
  assign core_cmd.packet_id = cmd.packet_id;

  mpbm_core #(
    .NODES(NODES), .PATTERNS(PATTERNS), .PACKET_BYTES(PACKET_BYTES)
  ) u_core (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd.valid), .cmd_ready(cmd.ready), .cmd(core_cmd),
    .res_valid(core_valid), .res_ready(core_ready), .res(core_res)
  );

  // output register, refilled in the cycle it drains
  assign core_ready = !ov || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (core_valid && core_ready) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && core_ready) begin
      ob <= core_res;
    end
  end

  assign rsp.valid          = ov;
  assign rsp.packet_id_out  = ob.packet_id_out;
  assign rsp.position       = ob.position;
  assign rsp.node_id        = ob.node_id;
  assign rsp.match_valid    = ob.match_valid;
  assign rsp.pattern_number = ob.pattern_number;
  assign rsp.result_last    = ob.result_last;
  assign rsp.build_report   = ob.build_report;
  assign rsp.status         = ob.status;
  assign rsp.node_count     = ob.node_count;

endmodule

// File: rtl/mpbm_ram.sv
// ----------------------------------------------------------------------------
// mpbm_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module mpbm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mpbm_core.sv
// ----------------------------------------------------------------------------
// mpbm_core
// Sequencer for trie insertion, breadth-first fail link build and scanning,
// around goto, fail, pattern mask and queue memories.
// ----------------------------------------------------------------------------
module mpbm_core #(
  parameter int NODES        = mpbm_pkg::NODES_DEF,
  parameter int PATTERNS     = mpbm_pkg::PATTERNS_DEF,
  parameter int PACKET_BYTES = mpbm_pkg::PACKET_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  mpbm_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output mpbm_pkg::res_t res
);

  localparam int NW  = $clog2(NODES);
  localparam int NCW = NW + 1;
  localparam int GAW = NW + 8;
  localparam int PW  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int PCW = $clog2(PATTERNS + 1);
  localparam logic [NCW-1:0] NODES_C    = NCW'(NODES);
  localparam logic [PCW-1:0] PATTERNS_C = PCW'(PATTERNS);
  localparam logic [15:0]    POS_CAP    =
    (PACKET_BYTES - 1 < 65535) ? 16'(PACKET_BYTES - 1) : 16'hFFFF;

  mpbm_pkg::state_t st, st_next;
  logic [7:0]          cb, cb_next;
  logic                lst, lst_next;
  logic [31:0]         pid, pid_next;
  logic [NW-1:0]       cur, cur_next;
  logic [NW-1:0]       cursor, cursor_next;
  logic [NCW-1:0]      nused, nused_next;
  logic [PCW-1:0]      pused, pused_next;
  logic [PATTERNS-1:0] found, found_next;
  logic [15:0]         offs, offs_next;
  logic                built, built_next;
  logic [1:0]          status, status_next;
  logic                dropped, dropped_next;
  logic [GAW-1:0]      clr_addr, clr_addr_next;
  logic [NCW-1:0]      head, head_next;
  logic [NCW-1:0]      tail, tail_next;
  logic [NW-1:0]       bnode, bnode_next;
  logic [NW-1:0]       fnode, fnode_next;
  logic [NW-1:0]       ch, ch_next;
  logic [7:0]          ch_idx, ch_idx_next;
  logic [NW-1:0]       fl, fl_next;
  logic [NW-1:0]       walk, walk_next;
  logic [PATTERNS-1:0] tmask, tmask_next;
  logic [PATTERNS-1:0] fresh, fresh_next;

  logic                g_we, f_we, m_we, q_we;
  logic [GAW-1:0]      g_waddr, g_raddr;
  logic [NW-1:0]       g_wdata, g_rdata;
  logic [NW-1:0]       f_waddr, f_raddr, f_wdata, f_rdata;
  logic [NW-1:0]       m_waddr, m_raddr;
  logic [PATTERNS-1:0] m_wdata, m_rdata;
  logic [NW-1:0]       q_waddr, q_raddr, q_wdata, q_rdata;

  logic [PW-1:0]       low_p;
  logic                only_one;

  mpbm_ram #(.DEPTH(NODES * 256), .WIDTH(NW)) u_goto (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
  );
  mpbm_ram #(.DEPTH(NODES), .WIDTH(NW)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );
  mpbm_ram #(.DEPTH(NODES), .WIDTH(PATTERNS)) u_mask (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );
  mpbm_ram #(.DEPTH(NODES), .WIDTH(NW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(q_raddr), .rdata(q_rdata)
  );

  // lowest pending pattern of this scan byte
  always_comb begin
    low_p = '0;
    for (int i = PATTERNS - 1; i >= 0; i--) begin
      if (fresh[i]) begin
        low_p = PW'(i);
      end
    end
  end

  assign only_one = (fresh & (fresh - 1'b1)) == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= mpbm_pkg::S_CLR;
      clr_addr <= '0;
      cur      <= '0;
      cursor   <= '0;
      nused    <= NCW'(1);
      pused    <= '0;
      found    <= '0;
      offs     <= '0;
      built    <= 1'b0;
      status   <= mpbm_pkg::ST_OK;
      dropped  <= 1'b0;
      head     <= '0;
      tail     <= '0;
      fresh    <= '0;
    end else begin
      st       <= st_next;
      clr_addr <= clr_addr_next;
      cur      <= cur_next;
      cursor   <= cursor_next;
      nused    <= nused_next;
      pused    <= pused_next;
      found    <= found_next;
      offs     <= offs_next;
      built    <= built_next;
      status   <= status_next;
      dropped  <= dropped_next;
      head     <= head_next;
      tail     <= tail_next;
      fresh    <= fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    cb     <= cb_next;
    lst    <= lst_next;
    pid    <= pid_next;
    bnode  <= bnode_next;
    fnode  <= fnode_next;
    ch     <= ch_next;
    ch_idx <= ch_idx_next;
    fl     <= fl_next;
    walk   <= walk_next;
    tmask  <= tmask_next;
  end

  always_comb begin
    st_next       = st;
    cb_next       = cb;
    lst_next      = lst;
    pid_next      = pid;
    cur_next      = cur;
    cursor_next   = cursor;
    nused_next    = nused;
    pused_next    = pused;
    found_next    = found;
    offs_next     = offs;
    built_next    = built;
    status_next   = status;
    dropped_next  = dropped;
    clr_addr_next = clr_addr;
    head_next     = head;
    tail_next     = tail;
    bnode_next    = bnode;
    fnode_next    = fnode;
    ch_next       = ch;
    ch_idx_next   = ch_idx;
    fl_next       = fl;
    walk_next     = walk;
    tmask_next    = tmask;
    fresh_next    = fresh;

    g_we = 1'b0; g_waddr = clr_addr; g_wdata = '0; g_raddr = {walk, cb};
    f_we = 1'b0; f_waddr = clr_addr[NW-1:0]; f_wdata = '0; f_raddr = walk;
    m_we = 1'b0; m_waddr = clr_addr[NW-1:0]; m_wdata = '0; m_raddr = cursor;
    q_we = 1'b0; q_waddr = tail[NW-1:0]; q_wdata = g_rdata; q_raddr = head[NW-1:0];

    cmd_ready = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    unique case (st)
      mpbm_pkg::S_CLR: begin
        g_we = 1'b1;
        f_we = 1'b1;
        m_we = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == '1) begin
          st_next = mpbm_pkg::S_IDLE;
        end
      end

      mpbm_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cb_next  = mpbm_pkg::fold(cmd.data_byte);
          lst_next = cmd.last;
          pid_next = cmd.packet_id;
          unique case (mpbm_pkg::func_t'(cmd.func))
            mpbm_pkg::FN_CLEAR: begin
              clr_addr_next = '0;
              cur_next      = '0;
              cursor_next   = '0;
              nused_next    = NCW'(1);
              pused_next    = '0;
              found_next    = '0;
              offs_next     = '0;
              built_next    = 1'b0;
              status_next   = mpbm_pkg::ST_OK;
              dropped_next  = 1'b0;
              st_next       = mpbm_pkg::S_CLR;
            end
            mpbm_pkg::FN_PATTERN: begin
              built_next = 1'b0;
              st_next    = mpbm_pkg::S_LD;
            end
            mpbm_pkg::FN_BUILD: begin
              st_next = mpbm_pkg::S_BD_INIT;
            end
            mpbm_pkg::FN_SCAN: begin
              walk_next = cur;
              st_next   = built ? mpbm_pkg::S_SC : mpbm_pkg::S_IDLE;
            end
            default: st_next = mpbm_pkg::S_IDLE;
          endcase
        end
      end

      // ---------------- pattern insertion ----------------
      mpbm_pkg::S_LD: begin
        g_raddr = {cursor, cb};
        if (pused >= PATTERNS_C) begin
          if (status == mpbm_pkg::ST_OK) begin
            status_next = mpbm_pkg::ST_PAT_FULL;
          end
          dropped_next = 1'b1;
          st_next      = mpbm_pkg::S_LD_END;
        end else if (dropped) begin
          st_next = mpbm_pkg::S_LD_END;
        end else begin
          st_next = mpbm_pkg::S_LD_W;
        end
      end

      mpbm_pkg::S_LD_W: begin
        if (g_rdata == '0) begin
          if (nused >= NODES_C) begin
            if (status == mpbm_pkg::ST_OK) begin
              status_next = mpbm_pkg::ST_NODE_FULL;
            end
            dropped_next = 1'b1;
          end else begin
            g_we        = 1'b1;
            g_waddr     = {cursor, cb};
            g_wdata     = nused[NW-1:0];
            cursor_next = nused[NW-1:0];
            nused_next  = nused + 1'b1;
          end
        end else begin
          cursor_next = g_rdata;
        end
        st_next = mpbm_pkg::S_LD_END;
      end

      mpbm_pkg::S_LD_END: begin
        m_raddr = cursor;
        st_next = mpbm_pkg::S_IDLE;
        if (lst) begin
          if (!dropped && cursor != '0 && pused < PATTERNS_C) begin
            st_next = mpbm_pkg::S_LD_MASK;
          end else begin
            cursor_next  = '0;
            dropped_next = 1'b0;
          end
        end
      end

      mpbm_pkg::S_LD_MASK: begin
        m_we         = 1'b1;
        m_waddr      = cursor;
        m_wdata      = m_rdata | (PATTERNS'(1) << pused);
        pused_next   = pused + 1'b1;
        cursor_next  = '0;
        dropped_next = 1'b0;
        st_next      = mpbm_pkg::S_IDLE;
      end

      // ---------------- fail link build ----------------
      mpbm_pkg::S_BD_INIT: begin
        f_we        = 1'b1;
        f_waddr     = '0;
        head_next   = '0;
        tail_next   = '0;
        ch_idx_next = '0;
        st_next     = mpbm_pkg::S_BR_RD;
      end

      mpbm_pkg::S_BR_RD: begin
        g_raddr = {NW'(0), ch_idx};
        st_next = mpbm_pkg::S_BR_CHK;
      end

      mpbm_pkg::S_BR_CHK: begin
        if (g_rdata != '0) begin
          f_we      = 1'b1;
          f_waddr   = g_rdata;
          q_we      = 1'b1;
          tail_next = tail + 1'b1;
        end
        ch_idx_next = ch_idx + 1'b1;
        st_next = (ch_idx == 8'hFF) ? mpbm_pkg::S_BQ : mpbm_pkg::S_BR_RD;
      end

      mpbm_pkg::S_BQ: begin
        st_next = (head < tail) ? mpbm_pkg::S_BQ_W : mpbm_pkg::S_BD_DONE;
      end

      mpbm_pkg::S_BQ_W: begin
        bnode_next = q_rdata;
        head_next  = head + 1'b1;
        f_raddr    = q_rdata;
        st_next    = mpbm_pkg::S_BN_F;
      end

      mpbm_pkg::S_BN_F: begin
        fnode_next  = f_rdata;
        ch_idx_next = '0;
        st_next     = mpbm_pkg::S_BC_RD;
      end

      mpbm_pkg::S_BC_RD: begin
        g_raddr = {bnode, ch_idx};
        st_next = mpbm_pkg::S_BC_CHK;
      end

      mpbm_pkg::S_BC_CHK: begin
        if (g_rdata == '0) begin
          ch_idx_next = ch_idx + 1'b1;
          st_next = (ch_idx == 8'hFF) ? mpbm_pkg::S_BQ : mpbm_pkg::S_BC_RD;
        end else begin
          q_we      = 1'b1;
          tail_next = tail + 1'b1;
          ch_next   = g_rdata;
          fl_next   = fnode;
          st_next   = mpbm_pkg::S_BF_RD;
        end
      end

      mpbm_pkg::S_BF_RD: begin
        g_raddr = {fl, ch_idx};
        f_raddr = fl;
        st_next = mpbm_pkg::S_BF_CHK;
      end

      mpbm_pkg::S_BF_CHK: begin
        if (fl != '0 && g_rdata == '0) begin
          fl_next = f_rdata;
          st_next = mpbm_pkg::S_BF_RD;
        end else begin
          f_we    = 1'b1;
          f_waddr = ch;
          f_wdata = (g_rdata == ch) ? '0 : g_rdata;
          m_raddr = f_wdata;
          st_next = mpbm_pkg::S_BM1;
        end
      end

      mpbm_pkg::S_BM1: begin
        tmask_next = m_rdata;
        m_raddr    = ch;
        st_next    = mpbm_pkg::S_BM2;
      end

      mpbm_pkg::S_BM2: begin
        m_we        = 1'b1;
        m_waddr     = ch;
        m_wdata     = m_rdata | tmask;
        ch_idx_next = ch_idx + 1'b1;
        st_next = (ch_idx == 8'hFF) ? mpbm_pkg::S_BQ : mpbm_pkg::S_BC_RD;
      end

      mpbm_pkg::S_BD_DONE: begin
        res_valid          = 1'b1;
        res.result_last    = 1'b1;
        res.build_report   = 1'b1;
        res.status         = status;
        res.node_count     = 9'(nused);
        if (res_ready) begin
          built_next = 1'b1;
          cur_next   = '0;
          found_next = '0;
          offs_next  = '0;
          st_next    = mpbm_pkg::S_IDLE;
        end
      end

      // ---------------- scanning ----------------
      mpbm_pkg::S_SC: begin
        g_raddr = {walk, cb};
        f_raddr = walk;
        st_next = mpbm_pkg::S_SC_CHK;
      end

      mpbm_pkg::S_SC_CHK: begin
        if (walk != '0 && g_rdata == '0) begin
          walk_next = f_rdata;
          st_next   = mpbm_pkg::S_SC;
        end else begin
          cur_next = (g_rdata != '0) ? g_rdata : walk;
          m_raddr  = cur_next;
          st_next  = mpbm_pkg::S_SC_M;
        end
      end

      mpbm_pkg::S_SC_M: begin
        fresh_next = m_rdata & ~found;
        found_next = found | m_rdata;
        st_next    = mpbm_pkg::S_SC_EMIT;
      end

      mpbm_pkg::S_SC_EMIT: begin
        res_valid          = 1'b1;
        res.packet_id_out  = pid;
        res.position       = offs;
        res.node_id        = 8'(cur);
        res.match_valid    = fresh != '0;
        res.pattern_number = (fresh != '0) ? 5'(low_p) : 5'd0;
        res.result_last    = only_one;
        res.status         = status;
        if (res_ready) begin
          fresh_next = fresh & (fresh - 1'b1);
          if (only_one) begin
            offs_next = (offs < POS_CAP) ? offs + 1'b1 : offs;
            if (lst) begin
              cur_next   = '0;
              found_next = '0;
              offs_next  = '0;
            end
            st_next = mpbm_pkg::S_IDLE;
          end
        end
      end

      default: st_next = mpbm_pkg::S_IDLE;
    endcase
  end

endmodule

// File: rtl/mpbm_checker.sv
// ----------------------------------------------------------------------------
// mpbm_checker
// Port-level checks on the result channel of the matcher.
// ----------------------------------------------------------------------------
module mpbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_packet_id_out,
  input logic [15:0] rsp_position,
  input logic [7:0]  rsp_node_id,
  input logic        rsp_match_valid,
  input logic        rsp_result_last,
  input logic        rsp_build_report,
  input logic [8:0]  rsp_node_count
);

  // a stalled transaction stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  // a build report is a single closing result with no scan fields
  a_build: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_build_report |-> rsp_result_last && !rsp_match_valid &&
      rsp_packet_id_out == 32'd0 && rsp_position == 16'd0 && rsp_node_id == 8'd0)
    else $error("malformed build report");

  // a scan byte with nothing new gives exactly one result
  a_nomatch: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_build_report && !rsp_match_valid |-> rsp_result_last)
    else $error("no-match result not closing");

  // scan results carry no node count
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_build_report |-> rsp_node_count == 9'd0)
    else $error("node count in scan result");

endmodule

bind multi_pattern_byte_matcher_top mpbm_checker u_mpbm_checker (
  .clk(clk),
  .rst(rst),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_packet_id_out(rsp.packet_id_out),
  .rsp_position(rsp.position),
  .rsp_node_id(rsp.node_id),
  .rsp_match_valid(rsp.match_valid),
  .rsp_result_last(rsp.result_last),
  .rsp_build_report(rsp.build_report),
  .rsp_node_count(rsp.node_count)
);
